[hw/rtl/swbcd_pkg.sv]
`timescale 1ns / 1ps
// swbcd_pkg: types, register indexes and the seven-segment table of the stopwatch
// used by stopwatch_bcd_seven_segment_top; depends on nothing else
package swbcd_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned DispCntW  = 16;
  localparam int unsigned ScanCntW  = 8;
  localparam int unsigned PressCntW = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned SegW      = 8;
  localparam int unsigned RunModeW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_DISPLAY_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCAN_PERIOD    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_COUNT = 2'd2;

  localparam logic [DispCntW-1:0]  DISPLAY_PERIOD_RST = 16'd100;
  localparam logic [ScanCntW-1:0]  SCAN_PERIOD_RST    = 8'd5;
  localparam logic [PressCntW-1:0] DEBOUNCE_COUNT_RST = 8'd5;

  localparam logic [PressCntW-1:0] PRESS_CNT_MAX = 8'd255;
  localparam logic [DigitW-1:0]    DIGIT_MAX     = 4'd9;

  localparam logic [RunModeW-1:0] RUN_MODE_STOPPED = 2'd0;
  localparam logic [RunModeW-1:0] RUN_MODE_RUNNING = 2'd1;
  localparam logic [RunModeW-1:0] RUN_MODE_PAUSED  = 2'd2;

  localparam logic [SegW-1:0] SEG_DP_CLEAR_MASK = 8'hfd;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'b001,
    MODE_RUNNING = 3'b010,
    MODE_PAUSED  = 3'b100
  } mode_t;

  typedef struct packed {
    logic            refresh;
    logic [SegW-1:0] seg_tens;
    logic [SegW-1:0] seg_units_dp;
    logic [SegW-1:0] seg_tenths;
    logic [SegW-1:0] seg_hundreds;
    logic [RunModeW-1:0] run_mode;
  } result_t;

  // active-low segments; codes above nine fold back modulo ten
  function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0, 4'd10: code = 8'h42;
      4'd1, 4'd11: code = 8'hf3;
      4'd2, 4'd12: code = 8'h86;
      4'd3, 4'd13: code = 8'ha2;
      4'd4, 4'd14: code = 8'h33;
      4'd5, 4'd15: code = 8'h2a;
      4'd6:        code = 8'h0a;
      4'd7:        code = 8'hf2;
      4'd8:        code = 8'h02;
      4'd9:        code = 8'h22;
      default:     code = 8'h42;
    endcase
    return code;
  endfunction

  function automatic logic [RunModeW-1:0] run_mode_code(input mode_t mode);
    logic [RunModeW-1:0] code;
    case (mode)
      MODE_STOPPED: code = RUN_MODE_STOPPED;
      MODE_RUNNING: code = RUN_MODE_RUNNING;
      MODE_PAUSED:  code = RUN_MODE_PAUSED;
      default:      code = RUN_MODE_STOPPED;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/stopwatch_bcd_seven_segment_top.sv]
`timescale 1ns / 1ps
// stopwatch_bcd_seven_segment_top: debounced start/pause and reset buttons, bcd count
// 000.0 to 999.9 and seven-segment codes, one result per 1 ms tick; uses swbcd_pkg
//
// Each input transfer is one tick and yields exactly one result transfer. The result is
// offered from the output buffer after its tick is accepted, unless earlier results are
// still waiting on the output side. A tick can be accepted in every cycle while in_stall
// is low: the state update and segment lookup are combinational between the input side
// and a two-entry output buffer, and in_stall rises only while the second entry holds
// a result not yet taken. Configuration writes act from the next tick onward.
module stopwatch_bcd_seven_segment_top
  import swbcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                button1_n,
  input  logic                button2_n,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                refresh,
  output logic [SegW-1:0]     seg_tens,
  output logic [SegW-1:0]     seg_units_dp,
  output logic [SegW-1:0]     seg_tenths,
  output logic [SegW-1:0]     seg_hundreds,
  output logic [RunModeW-1:0] run_mode
);

  logic [DispCntW-1:0]  display_period;
  logic [ScanCntW-1:0]  scan_period;
  logic [PressCntW-1:0] debounce_count;

  mode_t                mode, mode_next;
  logic [DigitW-1:0]    digit_hundreds, digit_hundreds_next;
  logic [DigitW-1:0]    digit_tens, digit_tens_next;
  logic [DigitW-1:0]    digit_units, digit_units_next;
  logic [DigitW-1:0]    digit_tenths, digit_tenths_next;
  logic [DispCntW-1:0]  display_tick_count, display_tick_count_next;
  logic [ScanCntW-1:0]  scan_tick_count, scan_tick_count_next;
  logic [PressCntW-1:0] press_count_one, press_count_one_next;
  logic [PressCntW-1:0] press_count_two, press_count_two_next;

  logic                 in_xfer, out_xfer;
  logic [ScanCntW-1:0]  scan_inc;
  logic                 scan_hit;
  logic [PressCntW-1:0] press_one_inc, press_two_inc;
  logic                 act_one, act_two;
  logic [DispCntW-1:0]  disp_inc;
  logic                 refresh_now;
  logic                 carry_tenths, carry_units, carry_tens;
  result_t              result_new;

  result_t              main_q, skid_q;
  logic                 main_valid, skid_valid;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid & ~skid_valid;
  assign out_xfer = main_valid & ~out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      display_period <= DISPLAY_PERIOD_RST;
      scan_period    <= SCAN_PERIOD_RST;
      debounce_count <= DEBOUNCE_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DISPLAY_PERIOD: display_period <= cfg_data;
        CFG_SCAN_PERIOD:    scan_period    <= cfg_data[ScanCntW-1:0];
        CFG_DEBOUNCE_COUNT: debounce_count <= cfg_data[PressCntW-1:0];
        default: ;
      endcase
    end
  end

  // scan and debounce
  always_comb begin
    scan_inc             = scan_tick_count + 1'b1;
    scan_hit             = (scan_inc >= scan_period);
    scan_tick_count_next = scan_hit ? '0 : scan_inc;
    press_one_inc        = press_count_one + 1'b1;
    press_two_inc        = press_count_two + 1'b1;

    press_count_one_next = press_count_one;
    act_one              = 1'b0;
    if (scan_hit) begin
      if (button1_n) begin
        press_count_one_next = '0;
      end else if (press_count_one != PRESS_CNT_MAX) begin
        press_count_one_next = press_one_inc;
        act_one              = (press_one_inc == debounce_count);
      end
    end

    press_count_two_next = press_count_two;
    act_two              = 1'b0;
    if (scan_hit) begin
      if (button2_n) begin
        press_count_two_next = '0;
      end else if (press_count_two != PRESS_CNT_MAX) begin
        press_count_two_next = press_two_inc;
        act_two              = (press_two_inc == debounce_count);
      end
    end

    mode_next = mode;
    if (act_one) begin
      mode_next = (mode == MODE_RUNNING) ? MODE_PAUSED : MODE_RUNNING;
    end
    if (act_two) begin
      mode_next = MODE_STOPPED;
    end
  end

  // refresh timing and bcd count
  always_comb begin
    refresh_now             = (display_tick_count == '0);
    disp_inc                = display_tick_count + 1'b1;
    display_tick_count_next = (disp_inc >= display_period) ? '0 : disp_inc;

    carry_tenths = (digit_tenths >= DIGIT_MAX);
    carry_units  = carry_tenths & (digit_units >= DIGIT_MAX);
    carry_tens   = carry_units & (digit_tens >= DIGIT_MAX);

    digit_hundreds_next = digit_hundreds;
    digit_tens_next     = digit_tens;
    digit_units_next    = digit_units;
    digit_tenths_next   = digit_tenths;
    if (refresh_now) begin
      case (mode_next)
        MODE_STOPPED: begin
          digit_hundreds_next = '0;
          digit_tens_next     = '0;
          digit_units_next    = '0;
          digit_tenths_next   = '0;
        end
        MODE_RUNNING: begin
          digit_tenths_next = carry_tenths ? '0 : digit_tenths + 1'b1;
          if (carry_tenths) begin
            digit_units_next = carry_units ? '0 : digit_units + 1'b1;
          end
          if (carry_units) begin
            digit_tens_next = carry_tens ? '0 : digit_tens + 1'b1;
          end
          if (carry_tens) begin
            digit_hundreds_next = (digit_hundreds >= DIGIT_MAX) ? '0
                                                                : digit_hundreds + 1'b1;
          end
        end
        default: ;
      endcase
    end

    result_new.refresh      = refresh_now;
    result_new.seg_tens     = seg_code(digit_tens_next);
    result_new.seg_units_dp = seg_code(digit_units_next) & SEG_DP_CLEAR_MASK;
    result_new.seg_tenths   = seg_code(digit_tenths_next);
    result_new.seg_hundreds = seg_code(digit_hundreds_next);
    result_new.run_mode     = run_mode_code(mode_next);
  end

  // tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_STOPPED;
      digit_hundreds     <= '0;
      digit_tens         <= '0;
      digit_units        <= '0;
      digit_tenths       <= '0;
      display_tick_count <= '0;
      scan_tick_count    <= '0;
      press_count_one    <= '0;
      press_count_two    <= '0;
    end else if (in_xfer) begin
      mode               <= mode_next;
      digit_hundreds     <= digit_hundreds_next;
      digit_tens         <= digit_tens_next;
      digit_units        <= digit_units_next;
      digit_tenths       <= digit_tenths_next;
      display_tick_count <= display_tick_count_next;
      scan_tick_count    <= scan_tick_count_next;
      press_count_one    <= press_count_one_next;
      press_count_two    <= press_count_two_next;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer || !main_valid) begin
      main_valid <= skid_valid | in_xfer;
      skid_valid <= 1'b0;
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer || !main_valid) begin
      main_q <= skid_valid ? skid_q : result_new;
    end else if (in_xfer) begin
      skid_q <= result_new;
    end
  end

  assign out_valid    = main_valid;
  assign refresh      = main_q.refresh;
  assign seg_tens     = main_q.seg_tens;
  assign seg_units_dp = main_q.seg_units_dp;
  assign seg_tenths   = main_q.seg_tenths;
  assign seg_hundreds = main_q.seg_hundreds;
  assign run_mode     = main_q.run_mode;

endmodule

[sim/tb_stopwatch_bcd_seven_segment_top.sv]
`timescale 1ns / 1ps
// tb_stopwatch_bcd_seven_segment_top: self-checking bench for the stopwatch tick pipeline,
// queue-fed tick driver, stalling result monitor and a tick-level stopwatch predictor
// depends on swbcd_pkg and stopwatch_bcd_seven_segment_top
module tb_stopwatch_bcd_seven_segment_top
  import swbcd_pkg::*;
();

  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic b1_n;
    logic b2_n;
  } tick_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                button1_n = 1'b1;
  logic                button2_n = 1'b1;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                refresh;
  logic [SegW-1:0]     seg_tens;
  logic [SegW-1:0]     seg_units_dp;
  logic [SegW-1:0]     seg_tenths;
  logic [SegW-1:0]     seg_hundreds;
  logic [RunModeW-1:0] run_mode;

  stopwatch_bcd_seven_segment_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .button1_n    (button1_n),
    .button2_n    (button2_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .refresh      (refresh),
    .seg_tens     (seg_tens),
    .seg_units_dp (seg_units_dp),
    .seg_tenths   (seg_tenths),
    .seg_hundreds (seg_hundreds),
    .run_mode     (run_mode)
  );

  tick_t   pending_ticks[$];
  result_t expected_frames[$];
  int      send_idle_pct = 33;
  int      recv_stall_pct = 86;
  int      mismatches = 0;
  int      cycles = 0;
  logic    in_fire_q = 1'b0;
  result_t seen_frame;
  result_t want_frame;
  result_t next_frame;

  // predictor state
  logic [DispCntW-1:0]  disp_period;
  logic [ScanCntW-1:0]  scan_period;
  logic [PressCntW-1:0] debounce_target;
  logic [RunModeW-1:0]  sw_mode;
  logic [DigitW-1:0]    d_hundreds, d_tens, d_units, d_tenths;
  logic [DispCntW-1:0]  disp_ticks;
  logic [ScanCntW-1:0]  scan_ticks;
  logic [PressCntW-1:0] press_one, press_two;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [SegW-1:0] glyph(input logic [DigitW-1:0] d);
    logic [SegW-1:0] g;
    case (d)
      4'd1:    g = 8'hf3;
      4'd2:    g = 8'h86;
      4'd3:    g = 8'ha2;
      4'd4:    g = 8'h33;
      4'd5:    g = 8'h2a;
      4'd6:    g = 8'h0a;
      4'd7:    g = 8'hf2;
      4'd8:    g = 8'h02;
      4'd9:    g = 8'h22;
      default: g = 8'h42;
    endcase
    return g;
  endfunction

  function automatic logic [PressCntW-1:0] next_press(input logic [PressCntW-1:0] cnt,
                                                      input logic pressed);
    if (!pressed) return '0;
    if (cnt == PRESS_CNT_MAX) return cnt;
    return cnt + 1'b1;
  endfunction

  task automatic reset_stopwatch();
    disp_period     = DISPLAY_PERIOD_RST;
    scan_period     = SCAN_PERIOD_RST;
    debounce_target = DEBOUNCE_COUNT_RST;
    sw_mode         = RUN_MODE_STOPPED;
    d_hundreds      = '0;
    d_tens          = '0;
    d_units         = '0;
    d_tenths        = '0;
    disp_ticks      = '0;
    scan_ticks      = '0;
    press_one       = '0;
    press_two       = '0;
  endtask

  task automatic advance_stopwatch(input logic b1_n, input logic b2_n, output result_t r);
    logic                 fire_one, fire_two, do_refresh;
    logic [PressCntW-1:0] cnt;
    scan_ticks = scan_ticks + 1'b1;
    if (scan_ticks >= scan_period) begin
      scan_ticks = '0;
      cnt = next_press(press_one, !b1_n);
      fire_one = !b1_n && (press_one != PRESS_CNT_MAX) && (cnt == debounce_target);
      press_one = cnt;
      cnt = next_press(press_two, !b2_n);
      fire_two = !b2_n && (press_two != PRESS_CNT_MAX) && (cnt == debounce_target);
      press_two = cnt;
      if (fire_one)
        sw_mode = (sw_mode == RUN_MODE_RUNNING) ? RUN_MODE_PAUSED : RUN_MODE_RUNNING;
      if (fire_two) sw_mode = RUN_MODE_STOPPED;
    end
    do_refresh = (disp_ticks == '0);
    disp_ticks = disp_ticks + 1'b1;
    if (disp_ticks >= disp_period) disp_ticks = '0;
    if (do_refresh) begin
      if (sw_mode == RUN_MODE_STOPPED) begin
        d_hundreds = '0;
        d_tens     = '0;
        d_units    = '0;
        d_tenths   = '0;
      end else if (sw_mode == RUN_MODE_RUNNING) begin
        // ripple carry through the bcd digits
        if (d_tenths == DIGIT_MAX) begin
          d_tenths = '0;
          if (d_units == DIGIT_MAX) begin
            d_units = '0;
            if (d_tens == DIGIT_MAX) begin
              d_tens = '0;
              d_hundreds = (d_hundreds == DIGIT_MAX) ? '0 : d_hundreds + 1'b1;
            end else begin
              d_tens = d_tens + 1'b1;
            end
          end else begin
            d_units = d_units + 1'b1;
          end
        end else begin
          d_tenths = d_tenths + 1'b1;
        end
      end
    end
    r.refresh      = do_refresh;
    r.seg_tens     = glyph(d_tens);
    r.seg_units_dp = glyph(d_units) & SEG_DP_CLEAR_MASK;
    r.seg_tenths   = glyph(d_tenths);
    r.seg_hundreds = glyph(d_hundreds);
    r.run_mode     = sw_mode;
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  // tick driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        button1_n <= pending_ticks[0].b1_n;
        button2_n <= pending_ticks[0].b2_n;
        void'(pending_ticks.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // predictor and result monitor
  always @(posedge clk) begin
    if (rst) begin
      reset_stopwatch();
      in_fire_q <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_DISPLAY_PERIOD: disp_period = cfg_data;
          CFG_SCAN_PERIOD:    scan_period = cfg_data[ScanCntW-1:0];
          CFG_DEBOUNCE_COUNT: debounce_target = cfg_data[PressCntW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen_frame = '{refresh, seg_tens, seg_units_dp, seg_tenths, seg_hundreds, run_mode};
        if (expected_frames.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want_frame = expected_frames.pop_front();
          check_field("refresh", 8'(seen_frame.refresh), 8'(want_frame.refresh));
          check_field("seg_tens", seen_frame.seg_tens, want_frame.seg_tens);
          check_field("seg_units_dp", seen_frame.seg_units_dp, want_frame.seg_units_dp);
          check_field("seg_tenths", seen_frame.seg_tenths, want_frame.seg_tenths);
          check_field("seg_hundreds", seen_frame.seg_hundreds, want_frame.seg_hundreds);
          check_field("run_mode", 8'(seen_frame.run_mode), 8'(want_frame.run_mode));
        end
      end
      in_fire_q <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        advance_stopwatch(button1_n, button2_n, next_frame);
        expected_frames.push_back(next_frame);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("stopwatch_bcd_seven_segment_top test failed");
      $finish;
    end
  end

  task automatic push_ticks(input logic b1_n, input logic b2_n, input int n);
    tick_t t;
    t.b1_n = b1_n;
    t.b2_n = b2_n;
    repeat (n) pending_ticks.push_back(t);
  endtask

  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] disp, input logic [7:0] scan,
                               input logic [7:0] deb);
    logic [7:0]  junk;
    logic [15:0] spare;
    wait_idle();
    write_reg(CFG_DISPLAY_PERIOD, disp);
    junk = 8'($urandom_range(0, 255));
    write_reg(CFG_SCAN_PERIOD, {junk, scan});
    junk = 8'($urandom_range(0, 255));
    write_reg(CFG_DEBOUNCE_COUNT, {junk, deb});
    spare = 16'($urandom_range(0, 65535));
    write_reg(CFG_UNUSED_IDX, spare);
    repeat (2) @(posedge clk);
  endtask

  // mostly full-length presses, some cut short, some random chatter
  task automatic queue_presses(input int n, input int scan, input int deb);
    int added, scan_eff, need, hold, gap, k;
    scan_eff = (scan < 1) ? 1 : scan;
    need = scan_eff * ((deb < 1) ? 3 : deb);
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 2) hold = $urandom_range(1, need);
        else hold = need + $urandom_range(0, 2 * scan_eff);
        if (hold > 600) hold = 600;
        gap = $urandom_range(1, 3 * scan_eff + 2);
        if (gap > 300) gap = 300;
        push_ticks(k >= 75, k < 60, hold);
        push_ticks(1'b1, 1'b1, gap);
        added += hold + gap;
      end else begin
        k = $urandom_range(1, 8);
        repeat (k) push_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
        added += k;
      end
    end
  endtask

  initial begin
    int d, s, b;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first tick refreshes, press too short to act
    push_ticks(1'b0, 1'b1, 12);
    push_ticks(1'b1, 1'b1, 1);

    // single-tick presses: start, pause, held press, resume, stop, both at once
    load_settings(16'd1, 8'd1, 8'd1);
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b1, 1);
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b1, 2);
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b1, 1);
    push_ticks(1'b1, 1'b0, 1);
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b0, 1);
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b1, 1);
    push_ticks(1'b1, 1'b1, 2);
    push_ticks(1'b1, 1'b0, 1);

    load_settings(16'd2, 8'd1, 8'd1);
    queue_presses(220, 1, 1);
    load_settings(16'd1, 8'd3, 8'd2);
    queue_presses(220, 3, 2);
    load_settings(16'd7, 8'd2, 8'd4);
    queue_presses(220, 2, 4);

    load_settings(16'd65535, 8'd255, 8'd254);
    send_idle_pct = 86;
    recv_stall_pct = 33;
    queue_presses(250, 255, 254);
    load_settings(16'd1, 8'd1, 8'd255);
    queue_presses(300, 1, 255);
    load_settings(16'd5, 8'd0, 8'd0);
    queue_presses(220, 0, 0);

    load_settings(16'd0, 8'd1, 8'd3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_presses(220, 1, 3);
    repeat (2) begin
      d = $urandom_range(1, 20);
      s = $urandom_range(1, 4);
      b = $urandom_range(1, 6);
      load_settings(d[15:0], s[7:0], b[7:0]);
      queue_presses(220, s, b);
    end

    // stop, start and run with a refresh on every tick
    load_settings(16'd1, 8'd1, 8'd1);
    push_ticks(1'b1, 1'b1, 2);
    push_ticks(1'b1, 1'b0, 1);
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b1, 1);
    push_ticks(1'b1, 1'b1, 200);

    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_frames.size() != 0) report_mismatch("expected results left over");
    if (mismatches == 0) begin
      $display("stopwatch_bcd_seven_segment_top test passed");
    end else begin
      $display("stopwatch_bcd_seven_segment_top test failed");
    end
    $finish;
  end

endmodule
